FILE: rtl/assert_macros.svh
// Assertion macros used by the file that carries concurrent checks.
// Both expect signals named clk and arst_n in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define NSS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define NSS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/nss_pkg.sv
package nss_pkg;

	// Destination fixed point and border scale format.
	localparam int FRAC_BITS   = 4;
	localparam int SCALE_FRAC  = 8;
	localparam int ROUND_SHIFT = SCALE_FRAC - FRAC_BITS;
	localparam int ROUND_ADD   = (ROUND_SHIFT == 0) ? 0 : (1 << (ROUND_SHIFT - 1));

	localparam int BORDER_W = 10;
	localparam int SCALE_W  = 12;
	localparam int PROD_W   = BORDER_W + SCALE_W;
	localparam int SCL_W    = PROD_W - ROUND_SHIFT;

	localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(256);

	// Signed working widths for the source and destination edge sums.
	localparam int SMATH_W = 14;
	localparam int DMATH_W = ((SCL_W > 17) ? SCL_W : 17) + 3;

	localparam int PIECE_W = 4;
	localparam logic [PIECE_W-1:0] PIECE_LAST = PIECE_W'(8);
	localparam logic [1:0] GRID_LAST = 2'd2;

	// Queue between the front and back ends.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [11:0]        src_x;
		logic [11:0]        src_y;
		logic [11:0]        src_w;
		logic [11:0]        src_h;
		logic signed [15:0] dst_x;
		logic signed [15:0] dst_y;
		logic [15:0]        dst_w;
		logic [15:0]        dst_h;
		logic [9:0]         border_left;
		logic [9:0]         border_right;
		logic [9:0]         border_top;
		logic [9:0]         border_bottom;
	} req_t;

	typedef struct packed {
		logic [PIECE_W-1:0] piece;
		logic [12:0]        piece_src_x;
		logic [12:0]        piece_src_y;
		logic [11:0]        piece_src_w;
		logic [11:0]        piece_src_h;
		logic signed [15:0] piece_dst_x;
		logic signed [15:0] piece_dst_y;
		logic [15:0]        piece_dst_w;
		logic [15:0]        piece_dst_h;
		logic               last_piece;
	} piece_t;

	// Finished 3x3 grid: three columns and three rows, already clamped.
	typedef struct packed {
		logic [2:0][12:0] scx;
		logic [2:0][11:0] scw;
		logic [2:0][12:0] scy;
		logic [2:0][11:0] sch;
		logic [2:0][15:0] dcx;
		logic [2:0][15:0] dcw;
		logic [2:0][15:0] dcy;
		logic [2:0][15:0] dch;
	} grid_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [15:0] sat_s16(input logic signed [DMATH_W-1:0] v);
		return (v > DMATH_W'(32767)) ? 16'h7FFF :
		       (v < DMATH_W'(-32768)) ? 16'h8000 : v[15:0];
	endfunction

	function automatic logic [15:0] clamp_u16(input logic signed [DMATH_W-1:0] v);
		return (v < 0) ? 16'h0000 : (v > DMATH_W'(65535)) ? 16'hFFFF : v[15:0];
	endfunction

	function automatic logic [12:0] clamp_u13(input logic signed [SMATH_W-1:0] v);
		return (v < 0) ? 13'd0 : v[12:0];
	endfunction

	function automatic logic [11:0] clamp_u12(input logic signed [SMATH_W-1:0] v);
		return (v < 0) ? 12'd0 : v[11:0];
	endfunction

endpackage

FILE: rtl/nss_req_if.sv
interface nss_req_if;
	import nss_pkg::*;

	logic valid;
	logic ready;
	req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/nss_piece_if.sv
interface nss_piece_if;
	import nss_pkg::*;

	logic   valid;
	logic   ready;
	piece_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/nine_slice_rect_splitter_unit.sv
// Nine-slice rectangle splitter.
// One draw request enters on the req channel (valid/ready): a source texel
// rectangle, a destination rectangle in signed fixed point with four fraction
// bits, and four border widths. The block answers on the piece channel with
// nine source/destination rectangle pairs, top left first in row order; the
// ninth carries last_piece.
// The request passes through both front-end stages and the grid queue into
// the output register before the first piece is valid; the remaining eight
// follow one a cycle from the single output register while the receiver keeps
// ready high. The front end takes the next request while the current one is
// still being delivered, so requests flow with no gap between their pieces.
// When the receiver holds ready low the current piece stays put; the
// two-entry grid queue fills, then both front-end stages, and only then does
// req.ready fall.
// The user must write the border scale via cfg_we/cfg_wdata only while the
// block is idle; the block does not enforce it. Reset clears every valid flag,
// empties the queue and sets the border scale to 1.0 (256 in the 4.8 format).
`include "assert_macros.svh"

module nine_slice_rect_splitter_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	nss_req_if.sink                     req,
	nss_piece_if.source                 piece,
	input  logic                        cfg_we,
	input  logic [nss_pkg::SCALE_W-1:0] cfg_wdata
);
	import nss_pkg::*;

	// Border scale register, taken as it stands by the front end.
	logic [SCALE_W-1:0] inset_scale_q;

	// Queue traffic between the two halves.
	logic    q_push;
	logic    q_pop;
	grid_t   q_entry;
	grid_t   q_head;
	q_stat_t q_stat;

	// Shorthand for the piece channel, used by the checks below.
	logic               pc_mid;
	logic               pc_last;
	logic [PIECE_W-1:0] pc_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inset_scale_q <= SCALE_RESET;
		end else if (cfg_we) begin
			inset_scale_q <= cfg_wdata;
		end
	end

	// The front end scales the borders and builds the complete grid of one
	// request, then parks it in the queue.
	nss_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.inset_scale (inset_scale_q),
		.q_push      (q_push),
		.q_entry     (q_entry),
		.q_stat      (q_stat)
	);

	nss_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.pop        (q_pop),
		.head       (q_head),
		.stat       (q_stat)
	);

	// The back end walks the nine cells of the grid at the head of the queue
	// and releases the entry as the ninth piece is loaded.
	nss_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.q_stat (q_stat),
		.q_pop  (q_pop),
		.piece  (piece)
	);

	assign pc_last = piece.data.last_piece;
	assign pc_idx  = piece.data.piece;
	assign pc_mid  = piece.valid && piece.ready && !pc_last;

	// The queue is never written while it is full.
	`NSS_ASSERT(a_no_overflow, q_stat.full |-> !q_push, "grid queue written while full")

	// Pieces of one request leave in strict index order.
	`NSS_ASSERT(a_piece_order, pc_mid |=> !piece.valid || pc_idx == $past(pc_idx) + 4'd1, "piece skipped")

	// The last flag marks the ninth piece and no other.
	`NSS_ASSERT(a_last_flag, piece.valid |-> pc_last == (pc_idx == PIECE_LAST), "last flag misplaced")

	// No piece is offered while reset is applied.
	`NSS_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !piece.valid, "piece valid during reset")
endmodule

FILE: rtl/nss_queue.sv
module nss_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  nss_pkg::grid_t   push_entry,
	input  logic             pop,
	output nss_pkg::grid_t   head,
	output nss_pkg::q_stat_t stat
);
	import nss_pkg::*;

	grid_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= next_ptr(wr_q);
			end
			if (pop) begin
				rd_q <= next_ptr(rd_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	assign head       = mem_q[rd_q];
	assign stat.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign stat.empty = (cnt_q == '0);
endmodule

FILE: rtl/nss_front.sv
module nss_front (
	input  logic                         clk,
	input  logic                         arst_n,
	nss_req_if.sink                      req,
	input  logic [nss_pkg::SCALE_W-1:0]  inset_scale,
	output logic                         q_push,
	output nss_pkg::grid_t               q_entry,
	input  nss_pkg::q_stat_t             q_stat
);
	import nss_pkg::*;

	logic                   v_s1;
	req_t                   req_s1;
	logic [3:0][PROD_W-1:0] prod_s1;

	logic                   v_s2;
	req_t                   req_s2;
	logic [3:0][SCL_W-1:0]  scl_s2;

	logic                   adv_s2;
	logic [3:0][PROD_W-1:0] rounded;

	logic signed [SMATH_W-1:0] sx, sy, sw, sh, bl, br, bt, bb;
	logic signed [DMATH_W-1:0] dx, dy, dw, dh, sl, sr, st, sbm;

	assign q_push    = v_s2 && !q_stat.full;
	assign adv_s2    = v_s1 && (!v_s2 || q_push);
	assign req.ready = !v_s1 || !v_s2 || q_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				v_s1 <= 1'b1;
			end else if (adv_s2) begin
				v_s1 <= 1'b0;
			end
			if (adv_s2) begin
				v_s2 <= 1'b1;
			end else if (q_push) begin
				v_s2 <= 1'b0;
			end
		end
	end

	// Border products in 8 fraction bits.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1     <= req.data;
			prod_s1[0] <= PROD_W'(req.data.border_left) * PROD_W'(inset_scale);
			prod_s1[1] <= PROD_W'(req.data.border_right) * PROD_W'(inset_scale);
			prod_s1[2] <= PROD_W'(req.data.border_top) * PROD_W'(inset_scale);
			prod_s1[3] <= PROD_W'(req.data.border_bottom) * PROD_W'(inset_scale);
		end
	end

	// Round half up into the destination fraction width.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			rounded[i] = prod_s1[i] + PROD_W'(ROUND_ADD);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			req_s2 <= req_s1;
			for (int i = 0; i < 4; i++) begin
				scl_s2[i] <= rounded[i][PROD_W-1:ROUND_SHIFT];
			end
		end
	end

	assign sx  = SMATH_W'(req_s2.src_x);
	assign sy  = SMATH_W'(req_s2.src_y);
	assign sw  = SMATH_W'(req_s2.src_w);
	assign sh  = SMATH_W'(req_s2.src_h);
	assign bl  = SMATH_W'(req_s2.border_left);
	assign br  = SMATH_W'(req_s2.border_right);
	assign bt  = SMATH_W'(req_s2.border_top);
	assign bb  = SMATH_W'(req_s2.border_bottom);
	assign dx  = DMATH_W'(req_s2.dst_x);
	assign dy  = DMATH_W'(req_s2.dst_y);
	assign dw  = DMATH_W'(req_s2.dst_w);
	assign dh  = DMATH_W'(req_s2.dst_h);
	assign sl  = DMATH_W'(scl_s2[0]);
	assign sr  = DMATH_W'(scl_s2[1]);
	assign st  = DMATH_W'(scl_s2[2]);
	assign sbm = DMATH_W'(scl_s2[3]);

	always_comb begin
		q_entry.scx[0] = 13'(req_s2.src_x);
		q_entry.scx[1] = clamp_u13(sx + bl);
		q_entry.scx[2] = clamp_u13(sx + sw - br);
		q_entry.scw[0] = 12'(req_s2.border_left);
		q_entry.scw[1] = clamp_u12(sw - bl - br);
		q_entry.scw[2] = 12'(req_s2.border_right);

		q_entry.scy[0] = 13'(req_s2.src_y);
		q_entry.scy[1] = clamp_u13(sy + bt);
		q_entry.scy[2] = clamp_u13(sy + sh - bb);
		q_entry.sch[0] = 12'(req_s2.border_top);
		q_entry.sch[1] = clamp_u12(sh - bt - bb);
		q_entry.sch[2] = 12'(req_s2.border_bottom);

		q_entry.dcx[0] = req_s2.dst_x;
		q_entry.dcx[1] = sat_s16(dx + sl);
		q_entry.dcx[2] = sat_s16(dx + dw - sr);
		q_entry.dcw[0] = clamp_u16(sl);
		q_entry.dcw[1] = clamp_u16(dw - sl - sr);
		q_entry.dcw[2] = clamp_u16(sr);

		q_entry.dcy[0] = req_s2.dst_y;
		q_entry.dcy[1] = sat_s16(dy + st);
		q_entry.dcy[2] = sat_s16(dy + dh - sbm);
		q_entry.dch[0] = clamp_u16(st);
		q_entry.dch[1] = clamp_u16(dh - st - sbm);
		q_entry.dch[2] = clamp_u16(sbm);
	end
endmodule

FILE: rtl/nss_back.sv
module nss_back (
	input  logic             clk,
	input  logic             arst_n,
	input  nss_pkg::grid_t   head,
	input  nss_pkg::q_stat_t q_stat,
	output logic             q_pop,
	nss_piece_if.source      piece
);
	import nss_pkg::*;

	logic               out_v_q;
	piece_t             pc_q;
	logic [PIECE_W-1:0] idx_q;
	logic [1:0]         col_q;
	logic [1:0]         row_q;
	logic               load;
	logic               at_last;

	assign load    = !q_stat.empty && (!out_v_q || piece.ready);
	assign at_last = (idx_q == PIECE_LAST);
	assign q_pop   = load && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			idx_q   <= '0;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			if (load) begin
				out_v_q <= 1'b1;
			end else if (piece.ready) begin
				out_v_q <= 1'b0;
			end
			if (load) begin
				if (at_last) begin
					idx_q <= '0;
					col_q <= '0;
					row_q <= '0;
				end else begin
					idx_q <= idx_q + PIECE_W'(1);
					if (col_q == GRID_LAST) begin
						col_q <= '0;
						row_q <= row_q + 2'd1;
					end else begin
						col_q <= col_q + 2'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pc_q.piece       <= idx_q;
			pc_q.piece_src_x <= head.scx[col_q];
			pc_q.piece_src_w <= head.scw[col_q];
			pc_q.piece_src_y <= head.scy[row_q];
			pc_q.piece_src_h <= head.sch[row_q];
			pc_q.piece_dst_x <= head.dcx[col_q];
			pc_q.piece_dst_w <= head.dcw[col_q];
			pc_q.piece_dst_y <= head.dcy[row_q];
			pc_q.piece_dst_h <= head.dch[row_q];
			pc_q.last_piece  <= at_last;
		end
	end

	assign piece.valid = out_v_q;
	assign piece.data  = pc_q;
endmodule

FILE: bench/tb.sv
// Testbench for the nine-slice rectangle splitter.
// Requests are queued by the stimulus process and driven onto the request
// channel by a clocked driver. At each accepted request the driver works out
// the nine slices that must come back. A clocked monitor takes the slices off
// the piece channel and compares every field with the oldest slice still due.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import nss_pkg::*;

	// Cycles with no item moving on either channel before the run is abandoned.
	// The slowest correct run never stands still for longer than the longest random
	// stall, plus the settling pause and a register write between phases.
	localparam int STALL_LIMIT = 1000;
	// Cycles to wait once the last due slice has arrived.
	localparam int TAIL_CYCLES = 16;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [SCALE_W-1:0]  cfg_wdata;

	nss_req_if   req_ch();
	nss_piece_if piece_ch();

	nine_slice_rect_splitter_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.piece    (piece_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Requests not yet offered to the block, and slices still to come back.
	req_t   requests_waiting[$];
	piece_t slices_due[$];

	// Our own copy of the border scale, updated as the register write is issued.
	logic [SCALE_W-1:0] scale_now;

	int unsigned fault_count;
	int unsigned stall_cycles;
	int unsigned tx_gap;
	int unsigned rx_gap;
	// Set for the last part of the run, where neither side idles.
	bit          calm;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_error(input string msg);
		$display("ERROR t=%0t %s", $time, msg);
		fault_count++;
	endtask

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : (v > hi) ? hi : v;
	endfunction

	// A border in texels times the 4.8 scale gives 8 fraction bits. This is
	// brought down to the destination's fraction bits, rounding half up.
	function automatic longint to_dest_units(input longint b);
		longint prod;
		int     sh;
		prod = b * longint'(scale_now);
		sh = SCALE_FRAC - FRAC_BITS;
		if (sh == 0)
			return prod;
		return (prod + (longint'(1) << (sh - 1))) >>> sh;
	endfunction

	// Builds the 3x3 grid of one request and queues its nine slices in row
	// order. All sums are done at full width and clamped only at the end.
	function automatic void split_request(input req_t r);
		longint sx, sy, sw, sh, dx, dy, dw, dh;
		longint bl, br, bt, bb, sl, sr, st, sb;
		longint scol_x[3], scol_w[3], srow_y[3], srow_h[3];
		longint dcol_x[3], dcol_w[3], drow_y[3], drow_h[3];
		piece_t p;
		int     row, col;
		sx = longint'(r.src_x);
		sy = longint'(r.src_y);
		sw = longint'(r.src_w);
		sh = longint'(r.src_h);
		dx = longint'(r.dst_x);
		dy = longint'(r.dst_y);
		dw = longint'(r.dst_w);
		dh = longint'(r.dst_h);
		bl = longint'(r.border_left);
		br = longint'(r.border_right);
		bt = longint'(r.border_top);
		bb = longint'(r.border_bottom);
		sl = to_dest_units(bl);
		sr = to_dest_units(br);
		st = to_dest_units(bt);
		sb = to_dest_units(bb);

		// The centre column and row take what is left after both borders.
		scol_x[0] = sx;           scol_w[0] = bl;
		scol_x[1] = sx + bl;      scol_w[1] = sw - bl - br;
		scol_x[2] = sx + sw - br; scol_w[2] = br;
		srow_y[0] = sy;           srow_h[0] = bt;
		srow_y[1] = sy + bt;      srow_h[1] = sh - bt - bb;
		srow_y[2] = sy + sh - bb; srow_h[2] = bb;

		dcol_x[0] = dx;           dcol_w[0] = sl;
		dcol_x[1] = dx + sl;      dcol_w[1] = dw - sl - sr;
		dcol_x[2] = dx + dw - sr; dcol_w[2] = sr;
		drow_y[0] = dy;           drow_h[0] = st;
		drow_y[1] = dy + st;      drow_h[1] = dh - st - sb;
		drow_y[2] = dy + dh - sb; drow_h[2] = sb;

		for (int k = 0; k < 9; k++) begin
			row = k / 3;
			col = k % 3;
			p.piece       = PIECE_W'(k);
			// Source edges cannot go below zero; destination edges saturate.
			p.piece_src_x = 13'(clip(scol_x[col], 0, 8191));
			p.piece_src_y = 13'(clip(srow_y[row], 0, 8191));
			p.piece_src_w = 12'(clip(scol_w[col], 0, 4095));
			p.piece_src_h = 12'(clip(srow_h[row], 0, 4095));
			p.piece_dst_x = 16'(clip(dcol_x[col], -32768, 32767));
			p.piece_dst_y = 16'(clip(drow_y[row], -32768, 32767));
			p.piece_dst_w = 16'(clip(dcol_w[col], 0, 65535));
			p.piece_dst_h = 16'(clip(drow_h[row], 0, 65535));
			p.last_piece  = (p.piece == PIECE_LAST);
			slices_due.push_back(p);
		end
	endfunction

	function automatic req_t pack_req(input int sx, input int sy, input int sw, input int sh,
	                                  input int dx, input int dy, input int dw, input int dh,
	                                  input int bl, input int br, input int bt, input int bb);
		req_t r;
		r.src_x         = 12'(sx);
		r.src_y         = 12'(sy);
		r.src_w         = 12'(sw);
		r.src_h         = 12'(sh);
		r.dst_x         = 16'(dx);
		r.dst_y         = 16'(dy);
		r.dst_w         = 16'(dw);
		r.dst_h         = 16'(dh);
		r.border_left   = 10'(bl);
		r.border_right  = 10'(br);
		r.border_top    = 10'(bt);
		r.border_bottom = 10'(bb);
		return r;
	endfunction

	// One of zero, all ones, the top bit alone, all but the top bit, or noise,
	// at a field width of w bits. For signed fields these are -1, the most
	// negative and the most positive values.
	function automatic logic [15:0] extreme(input int w);
		logic [15:0] m;
		m = 16'((32'd1 << w) - 1);
		case ($urandom_range(0, 4))
			0: return '0;
			1: return m;
			2: return 16'(32'd1 << (w - 1));
			3: return m >> 1;
			default: return 16'($urandom) & m;
		endcase
	endfunction

	// Most requests are well formed: the borders fit inside both rectangles.
	// The rest are raw noise, field extremes, or very small rectangles.
	function automatic req_t random_request();
		req_t        r;
		logic [159:0] noise;
		int          w, h, a, b, c, d;
		longint      need;
		noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
		r = noise[$bits(req_t)-1:0];
		case ($urandom_range(0, 9))
			6, 7: begin
				// Raw noise as it stands.
			end
			8: begin
				r.src_x         = 12'(extreme(12));
				r.src_y         = 12'(extreme(12));
				r.src_w         = 12'(extreme(12));
				r.src_h         = 12'(extreme(12));
				r.dst_x         = extreme(16);
				r.dst_y         = extreme(16);
				r.dst_w         = extreme(16);
				r.dst_h         = extreme(16);
				r.border_left   = 10'(extreme(10));
				r.border_right  = 10'(extreme(10));
				r.border_top    = 10'(extreme(10));
				r.border_bottom = 10'(extreme(10));
			end
			9: begin
				r.src_w         = 12'($urandom_range(0, 15));
				r.src_h         = 12'($urandom_range(0, 15));
				r.dst_w         = 16'($urandom_range(0, 255));
				r.dst_h         = 16'($urandom_range(0, 255));
				r.border_left   = 10'($urandom_range(0, 7));
				r.border_right  = 10'($urandom_range(0, 7));
				r.border_top    = 10'($urandom_range(0, 7));
				r.border_bottom = 10'($urandom_range(0, 7));
			end
			default: begin
				w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 400);
				h = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 400);
				a = $urandom_range(0, (w < 1023) ? w : 1023);
				b = $urandom_range(0, ((w - a) < 1023) ? (w - a) : 1023);
				c = $urandom_range(0, (h < 1023) ? h : 1023);
				d = $urandom_range(0, ((h - c) < 1023) ? (h - c) : 1023);
				r.src_w         = 12'(w);
				r.src_h         = 12'(h);
				r.border_left   = 10'(a);
				r.border_right  = 10'(b);
				r.border_top    = 10'(c);
				r.border_bottom = 10'(d);
				// Give the destination room for both scaled borders where it can.
				need = to_dest_units(a) + to_dest_units(b);
				r.dst_w = (need <= 65535) ? 16'($urandom_range(65535, int'(need))) : 16'($urandom);
				need = to_dest_units(c) + to_dest_units(d);
				r.dst_h = (need <= 65535) ? 16'($urandom_range(65535, int'(need))) : 16'($urandom);
			end
		endcase
		return r;
	endfunction

	// Request driver. A new item is offered once the previous one has gone;
	// every accepted item is turned into its nine expected slices at once.
	always @(posedge clk) begin : drive_requests
		bit taken;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			tx_gap = 0;
		end else begin
			taken = req_ch.valid && req_ch.ready;
			if (taken)
				split_request(req_ch.data);
			if (!req_ch.valid || taken) begin
				if (tx_gap > 0) begin
					req_ch.valid <= 1'b0;
					tx_gap--;
				end else if (requests_waiting.size() > 0) begin
					req_ch.valid <= 1'b1;
					req_ch.data  <= requests_waiting.pop_front();
					// Now and then a burst of idle cycles follows this item.
					if (!calm && $urandom_range(0, 5) == 0)
						tx_gap = $urandom_range(1, 11);
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Slice monitor and receiver. Ready drops in random bursts so that the
	// output register and the grid queue are held in every state.
	always @(posedge clk) begin : take_slices
		piece_t want;
		piece_t got;
		if (!arst_n) begin
			piece_ch.ready <= 1'b0;
			rx_gap = 0;
		end else begin
			if (piece_ch.valid && piece_ch.ready) begin
				got = piece_ch.data;
				if (slices_due.size() == 0) begin
					report_error($sformatf("slice %0d arrived with nothing due", got.piece));
				end else begin
					want = slices_due.pop_front();
					if (got.piece != want.piece)
						report_error($sformatf("piece got %0d want %0d",
						             got.piece, want.piece));
					if (got.piece_src_x != want.piece_src_x)
						report_error($sformatf("slice %0d src_x got %0d want %0d",
						             want.piece, got.piece_src_x, want.piece_src_x));
					if (got.piece_src_y != want.piece_src_y)
						report_error($sformatf("slice %0d src_y got %0d want %0d",
						             want.piece, got.piece_src_y, want.piece_src_y));
					if (got.piece_src_w != want.piece_src_w)
						report_error($sformatf("slice %0d src_w got %0d want %0d",
						             want.piece, got.piece_src_w, want.piece_src_w));
					if (got.piece_src_h != want.piece_src_h)
						report_error($sformatf("slice %0d src_h got %0d want %0d",
						             want.piece, got.piece_src_h, want.piece_src_h));
					if (got.piece_dst_x != want.piece_dst_x)
						report_error($sformatf("slice %0d dst_x got %0d want %0d",
						             want.piece, got.piece_dst_x, want.piece_dst_x));
					if (got.piece_dst_y != want.piece_dst_y)
						report_error($sformatf("slice %0d dst_y got %0d want %0d",
						             want.piece, got.piece_dst_y, want.piece_dst_y));
					if (got.piece_dst_w != want.piece_dst_w)
						report_error($sformatf("slice %0d dst_w got %0d want %0d",
						             want.piece, got.piece_dst_w, want.piece_dst_w));
					if (got.piece_dst_h != want.piece_dst_h)
						report_error($sformatf("slice %0d dst_h got %0d want %0d",
						             want.piece, got.piece_dst_h, want.piece_dst_h));
					if (got.last_piece != want.last_piece)
						report_error($sformatf("slice %0d last got %0b want %0b",
						             want.piece, got.last_piece, want.last_piece));
				end
			end
			if (rx_gap > 0) begin
				piece_ch.ready <= 1'b0;
				rx_gap--;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				// This cycle opens a stall whose remaining length is drawn into rx_gap.
				piece_ch.ready <= 1'b0;
				rx_gap = $urandom_range(0, 10);
			end else begin
				piece_ch.ready <= 1'b1;
			end
		end
	end

	// Counts cycles in which no item moves on either channel.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (piece_ch.valid && piece_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin : watchdog
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		report_error($sformatf("nothing moved for %0d cycles, %0d slices still due",
		             STALL_LIMIT, slices_due.size()));
		$display("FAIL nine_slice_rect_splitter_unit");
		$finish;
	end

	// Waits until every queued request has been taken and every slice has
	// come back, then lets the pipeline drain before anything else happens.
	task automatic settle();
		while (requests_waiting.size() != 0 || req_ch.valid || slices_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_scale(input logic [SCALE_W-1:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		scale_now = v;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin : stimulus
		int unsigned scales[7];
		logic [SCALE_W-1:0] v;
		scales = '{0, 4095, 1, 8, 24, 0, 256};
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		req_ch.valid   = 1'b0;
		req_ch.data    = '0;
		piece_ch.ready = 1'b0;
		scale_now      = SCALE_RESET;
		fault_count    = 0;
		stall_cycles   = 0;
		calm           = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed requests at the reset scale of 1.0.
		requests_waiting.push_back(pack_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		requests_waiting.push_back(pack_req(4095, 4095, 4095, 4095, 32767, 32767,
		                                    65535, 65535, 1023, 1023, 1023, 1023));
		requests_waiting.push_back(pack_req(0, 0, 4095, 4095, -32768, -32768,
		                                    0, 0, 1023, 1023, 1023, 1023));
		requests_waiting.push_back(pack_req(100, 50, 64, 48, 160, 320, 1024, 768, 8, 8, 6, 6));
		// Borders wider than the source: negative centre and a source edge below zero.
		requests_waiting.push_back(pack_req(0, 0, 10, 10, 0, 0, 4096, 4096, 1023, 1023, 1023, 1023));
		requests_waiting.push_back(pack_req(4095, 4095, 4095, 4095, 0, 0, 4096, 4096, 0, 0, 0, 0));
		// Destination narrower than its two scaled borders.
		requests_waiting.push_back(pack_req(10, 10, 40, 40, 100, 100, 16, 16, 10, 10, 10, 10));
		// Destination edges beyond the top of the range.
		requests_waiting.push_back(pack_req(1, 2, 300, 300, 32767, 32767, 65535, 65535, 0, 0, 0, 0));
		requests_waiting.push_back(pack_req(1, 2, 300, 300, 30000, 30000, 40000, 40000,
		                                    200, 100, 200, 100));
		// Destination edges pushed below the bottom of the range.
		requests_waiting.push_back(pack_req(5, 5, 50, 50, -32768, -32768, 0, 0, 1023, 1023, 1023, 1023));
		requests_waiting.push_back(pack_req(7, 9, 200, 150, 480, 320, 3200, 2400, 0, 0, 0, 0));
		requests_waiting.push_back(pack_req(7, 9, 200, 150, 480, 320, 3200, 2400, 12, 0, 0, 0));
		requests_waiting.push_back(pack_req(7, 9, 200, 150, 480, 320, 3200, 2400, 0, 12, 0, 0));
		requests_waiting.push_back(pack_req(7, 9, 200, 150, 480, 320, 3200, 2400, 0, 0, 12, 0));
		requests_waiting.push_back(pack_req(7, 9, 200, 150, 480, 320, 3200, 2400, 0, 0, 0, 12));
		// Borders that just fill the source, and leave a centre of one texel.
		requests_waiting.push_back(pack_req(30, 30, 20, 20, 0, 0, 320, 320, 10, 10, 10, 10));
		requests_waiting.push_back(pack_req(30, 30, 21, 21, -16, -16, 336, 336, 10, 10, 10, 10));
		requests_waiting.push_back(pack_req(4000, 4000, 4095, 4095, -100, 100, 65535, 65535,
		                                    1023, 1, 1, 1023));
		for (int k = 0; k < 20; k++)
			requests_waiting.push_back(random_request());

		// Each later phase waits for the block to fall quiet, so the sender
		// pauses until every due slice has come, then sets a new scale.
		for (int ph = 0; ph < 7; ph++) begin
			settle();
			v = (ph == 5) ? SCALE_W'($urandom_range(0, 4095)) : SCALE_W'(scales[ph]);
			write_scale(v);
			if (ph == 6)
				calm = 1'b1;
			for (int k = 0; k < 34; k++)
				requests_waiting.push_back(random_request());
		end
		settle();

		if (fault_count == 0)
			$display("PASS nine_slice_rect_splitter_unit");
		else
			$display("FAIL nine_slice_rect_splitter_unit");
		$finish;
	end
endmodule
